/* src/pedestal_peak_finder_unit_macros.svh */
// assertion macros for the pedestal peak finder
`ifndef PEDESTAL_PEAK_FINDER_UNIT_MACROS_SVH
`define PEDESTAL_PEAK_FINDER_UNIT_MACROS_SVH

// property checked on every edge outside reset
`define PPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies condition in the next
`define PPF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* src/ppf_pkg.sv */
// shared constants and types of the pedestal peak finder
package ppf_pkg;

  localparam int PPF_NUM_SAMPLES      = 32;
  localparam int PPF_PEDESTAL_SAMPLES = 3;

  localparam int SAMPLE_W    = 14;
  localparam int SUM_W       = 16;
  localparam int PEAK_W      = 17;
  localparam int MAG_W       = 16;
  localparam int POS_W       = 5;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  typedef struct packed {
    logic                vld;
    logic [SAMPLE_W-1:0] sample;
  } ppf_item_t;

  typedef struct packed {
    logic [POS_W-1:0]         peak_position;
    logic signed [PEAK_W-1:0] peak_scaled;
    logic [SUM_W-1:0]         pedestal_sum;
  } ppf_result_t;

  typedef struct packed {
    logic adv;
    logic take;
    logic last;
  } ppf_stat_t;

endpackage

/* src/ppf_in_stage.sv */
// input register stage of the pedestal peak finder
module ppf_in_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ppf_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  ppf_pkg::ppf_stat_t              stat,
  output ppf_pkg::ppf_item_t              item
);
  import ppf_pkg::*;

  logic                vld_r, vld_nxt;
  logic [SAMPLE_W-1:0] sample_r;
  logic                load;

  assign in_tready = !vld_r || stat.adv;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    if (load) begin
      vld_nxt = 1'b1;
    end else if (stat.adv) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sample_r <= in_tdata[SAMPLE_W-1:0];
    end
  end

  assign item.vld    = vld_r;
  assign item.sample = sample_r;

endmodule

/* src/ppf_core.sv */
// frame state, peak compare and result register of the pedestal peak finder
module ppf_core #(
  parameter int NUM_SAMPLES      = ppf_pkg::PPF_NUM_SAMPLES,
  parameter int PEDESTAL_SAMPLES = ppf_pkg::PPF_PEDESTAL_SAMPLES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ppf_pkg::ppf_item_t    item,
  output ppf_pkg::ppf_stat_t    stat,
  output logic                  res_valid,
  input  logic                  res_ready,
  output ppf_pkg::ppf_result_t  res
);
  import ppf_pkg::*;

  localparam int IDX_W = $clog2(NUM_SAMPLES);

  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic signed [PEAK_W-1:0] best_dev_r, best_dev_nxt;
  logic [MAG_W-1:0]         best_mag_r, best_mag_nxt;
  logic [IDX_W-1:0]         best_idx_r, best_idx_nxt;
  logic                     out_vld_r, out_vld_nxt;
  ppf_result_t              res_r, res_nxt;

  logic                     in_ped, last, adv, take;
  logic [SUM_W-1:0]         scaled;
  logic signed [PEAK_W-1:0] dev;
  logic [MAG_W-1:0]         mag;
  logic                     better;

  assign in_ped = idx_r < IDX_W'(PEDESTAL_SAMPLES);
  assign last   = idx_r == IDX_W'(NUM_SAMPLES - 1);
  assign adv    = !last || !out_vld_r || res_ready;
  assign take   = item.vld && adv;

  assign scaled = SUM_W'({2'b00, item.sample} * SUM_W'(PEDESTAL_SAMPLES));
  assign dev    = $signed({1'b0, scaled}) - $signed({1'b0, sum_r});
  assign mag    = dev[PEAK_W-1] ? MAG_W'(-dev) : dev[MAG_W-1:0];
  assign better = mag > best_mag_r;

  always_comb begin
    idx_nxt      = idx_r;
    sum_nxt      = sum_r;
    best_dev_nxt = best_dev_r;
    best_mag_nxt = best_mag_r;
    best_idx_nxt = best_idx_r;
    out_vld_nxt  = out_vld_r && !res_ready;
    res_nxt      = res_r;
    if (take) begin
      if (in_ped) begin
        sum_nxt = sum_r + SUM_W'(item.sample);
      end else if (better) begin
        best_dev_nxt = dev;
        best_mag_nxt = mag;
        best_idx_nxt = idx_r;
      end
      if (last) begin
        out_vld_nxt           = 1'b1;
        res_nxt.pedestal_sum  = sum_nxt;
        res_nxt.peak_scaled   = best_dev_nxt;
        res_nxt.peak_position = POS_W'(best_idx_nxt);
        idx_nxt               = '0;
        sum_nxt               = '0;
        best_dev_nxt          = '0;
        best_mag_nxt          = '0;
        best_idx_nxt          = '0;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      sum_r      <= '0;
      best_dev_r <= '0;
      best_mag_r <= '0;
      best_idx_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      idx_r      <= idx_nxt;
      sum_r      <= sum_nxt;
      best_dev_r <= best_dev_nxt;
      best_mag_r <= best_mag_nxt;
      best_idx_r <= best_idx_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign stat.adv  = adv;
  assign stat.take = take;
  assign stat.last = last;
  assign res_valid = out_vld_r;
  assign res       = res_r;

endmodule

/* src/pedestal_peak_finder_unit.sv */
// a frame's result is registered and shows on out_tvalid once the core takes its last sample
// throughput: one sample per cycle; only a last sample whose result meets an untaken
// earlier result waits, held in the input register until the result register frees
// reset: synchronous active-low rst_n clears the frame index, pedestal sum, peak state
// and both valid flags; the first sample after reset starts a new frame
// top level of the pedestal peak finder
`include "pedestal_peak_finder_unit_macros.svh"

module pedestal_peak_finder_unit #(
  parameter int NUM_SAMPLES      = ppf_pkg::PPF_NUM_SAMPLES,
  parameter int PEDESTAL_SAMPLES = ppf_pkg::PPF_PEDESTAL_SAMPLES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [13:0] adc_sample, [15:14] zero
  input  logic [ppf_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [15:0] pedestal_sum, [32:16] peak_scaled, [37:33] peak_position, [39:38] zero
  output logic [ppf_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ppf_pkg::*;

  ppf_item_t   s1_item;
  ppf_stat_t   stat;
  ppf_result_t res;

  ppf_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .stat      (stat),
    .item      (s1_item)
  );

  ppf_core #(
    .NUM_SAMPLES      (NUM_SAMPLES),
    .PEDESTAL_SAMPLES (PEDESTAL_SAMPLES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (s1_item),
    .stat      (stat),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {2'b00, res.peak_position, res.peak_scaled, res.pedestal_sum};

  `PPF_ASSERT(a_stall_cause,
    !in_tready |-> (s1_item.vld && out_tvalid && !out_tready),
    "input stalled without a blocked result")
  `PPF_ASSERT_NEXT(a_result_follows, stat.take && stat.last, out_tvalid,
    "last sample gave no result")
  `PPF_ASSERT(a_no_spurious, $rose(out_tvalid) |-> $past(stat.take && stat.last),
    "result without a last sample")

endmodule
